>>> src/fenwick_2d_point_update_rect_sum_assert.svh
// ----------------------------------------------------------------------------
// fenwick_2d_point_update_rect_sum assertion macros
// Shared property forms for the checker of the 2-D Fenwick tree block.
// ----------------------------------------------------------------------------
`ifndef FENWICK_2D_POINT_UPDATE_RECT_SUM_ASSERT_SVH
`define FENWICK_2D_POINT_UPDATE_RECT_SUM_ASSERT_SVH

// same-cycle implication, masked in reset
`define FW2D_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked in reset
`define FW2D_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live through reset
`define FW2D_ASSERT_NXT_ALL(label, ck, ante, cons, msg) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fw2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_pkg
// Types, codes and widths shared by the 2-D Fenwick tree block.
// ----------------------------------------------------------------------------
package fw2d_pkg;

  localparam int GRID_DIM_DEF = 512;

  localparam int DATA_W    = 32;
  localparam int COORD_W   = 10;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] USED_RESET = 10'd512;

  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHRD,
    ST_DELTA,
    ST_SHWR,
    ST_UPD,
    ST_QRY,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_CLR,
    ALU_LOAD,
    ALU_DSET,
    ALU_SHADOW,
    ALU_TREE,
    ALU_ACC_ADD,
    ALU_ACC_SUB
  } alu_op_t;

endpackage

>>> src/fw2d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module fw2d_ram #(
  parameter int AW = 18,
  parameter int DW = fw2d_pkg::DATA_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/fw2d_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_alu
// Shared 32-bit add/subtract unit with the delta and accumulator registers.
// ----------------------------------------------------------------------------
module fw2d_alu (
  input  logic                         clk,
  input  fw2d_pkg::alu_op_t            op,
  input  logic [fw2d_pkg::DATA_W-1:0]  value,
  input  logic [fw2d_pkg::DATA_W-1:0]  tree_rd,
  input  logic [fw2d_pkg::DATA_W-1:0]  shadow_rd,
  output logic [fw2d_pkg::DATA_W-1:0]  sum,
  output logic [fw2d_pkg::DATA_W-1:0]  acc
);

  logic [fw2d_pkg::DATA_W-1:0] delta;
  logic [fw2d_pkg::DATA_W-1:0] opa;
  logic [fw2d_pkg::DATA_W-1:0] opb;
  logic                        neg;

  always_comb begin
    opa = '0;
    opb = '0;
    neg = 1'b0;
    case (op)
      fw2d_pkg::ALU_LOAD: begin
        opa = value;
      end
      fw2d_pkg::ALU_DSET: begin
        opa = delta;
        opb = shadow_rd;
        neg = 1'b1;
      end
      fw2d_pkg::ALU_SHADOW: begin
        opa = shadow_rd;
        opb = delta;
      end
      fw2d_pkg::ALU_TREE: begin
        opa = tree_rd;
        opb = delta;
      end
      fw2d_pkg::ALU_ACC_ADD: begin
        opa = acc;
        opb = tree_rd;
      end
      fw2d_pkg::ALU_ACC_SUB: begin
        opa = acc;
        opb = tree_rd;
        neg = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum = opa + (neg ? ~opb : opb) + {{(fw2d_pkg::DATA_W-1){1'b0}}, neg};

  // delta holds the increment: value for add, value minus old cell for set
  always_ff @(posedge clk) begin
    case (op)
      fw2d_pkg::ALU_LOAD,
      fw2d_pkg::ALU_DSET:    delta <= sum;
      fw2d_pkg::ALU_CLR:     acc   <= '0;
      fw2d_pkg::ALU_ACC_ADD,
      fw2d_pkg::ALU_ACC_SUB: acc   <= sum;
      default: begin
      end
    endcase
  end

endmodule

>>> src/fw2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_ctrl
// Sequencer: clear sweep, coordinate checks, Fenwick index walks, result.
// ----------------------------------------------------------------------------
module fw2d_ctrl #(
  parameter int GRID_DIM = fw2d_pkg::GRID_DIM_DEF,
  parameter int CW       = $clog2(GRID_DIM),
  parameter int AW       = 2 * CW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  logic [fw2d_pkg::MODE_W-1:0]        mode,
  input  logic [fw2d_pkg::COORD_W-1:0]       row_lo,
  input  logic [fw2d_pkg::COORD_W-1:0]       col_lo,
  input  logic [fw2d_pkg::COORD_W-1:0]       row_hi,
  input  logic [fw2d_pkg::COORD_W-1:0]       col_hi,
  input  logic [fw2d_pkg::CFG_W-1:0]         rows_used,
  input  logic [fw2d_pkg::CFG_W-1:0]         cols_used,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [fw2d_pkg::DATA_W-1:0] range_sum,
  output logic                               status,
  input  logic [fw2d_pkg::DATA_W-1:0]        acc,
  output fw2d_pkg::alu_op_t                  alu_op,
  output logic                               clearing,
  output logic [AW-1:0]                      tree_raddr,
  output logic                               tree_we,
  output logic [AW-1:0]                      tree_waddr,
  output logic [AW-1:0]                      shadow_raddr,
  output logic                               shadow_we,
  output logic [AW-1:0]                      shadow_waddr
);

  localparam int IW = CW + 2;
  localparam int VW = (IW > fw2d_pkg::COORD_W) ? IW : fw2d_pkg::COORD_W;

  fw2d_pkg::state_t state;
  fw2d_pkg::state_t state_next;

  logic [AW-1:0] clr_addr;
  logic [IW-1:0] lat_rlo;
  logic [IW-1:0] lat_clo;
  logic [IW-1:0] lat_rhi;
  logic [IW-1:0] lat_chi;
  logic          lat_set;
  logic          lat_query;
  logic          bad;
  logic [IW-1:0] wi;
  logic [IW-1:0] wj;
  logic [IW-1:0] col_base;
  logic [1:0]    pk;
  logic          pipe_v;
  logic          pipe_neg;
  logic [AW-1:0] pipe_addr;

  logic [VW-1:0] eff_rows;
  logic [VW-1:0] eff_cols;
  logic [VW-1:0] rlo_x;
  logic [VW-1:0] clo_x;
  logic [VW-1:0] rhi_x;
  logic [VW-1:0] chi_x;
  logic          upd_ok;
  logic          qry_ok;
  logic          take;
  logic          issue;
  logic          finish;

  logic [IW-1:0] lb_i;
  logic [IW-1:0] lb_j;
  logic [IW-1:0] i_up;
  logic [IW-1:0] j_up;
  logic [IW-1:0] i_dn;
  logic [IW-1:0] j_dn;
  logic          i_up_end;
  logic          j_up_end;
  logic          i_dn_end;
  logic          j_dn_end;
  logic          q_empty;
  logic          q_step;
  logic          q_last;
  logic [1:0]    pk_n;
  logic [IW-1:0] nrow;
  logic [IW-1:0] ncol;
  logic [IW-1:0] wi_m1;
  logic [IW-1:0] wj_m1;
  logic [IW-1:0] rlo_m1;
  logic [IW-1:0] clo_m1;

  // coordinate checks
  always_comb begin
    eff_rows = (VW'(rows_used) > VW'(GRID_DIM)) ? VW'(GRID_DIM) : VW'(rows_used);
    eff_cols = (VW'(cols_used) > VW'(GRID_DIM)) ? VW'(GRID_DIM) : VW'(cols_used);
    rlo_x    = VW'(row_lo);
    clo_x    = VW'(col_lo);
    rhi_x    = VW'(row_hi);
    chi_x    = VW'(col_hi);
    upd_ok   = (rlo_x != '0) && (rlo_x <= eff_rows) &&
               (clo_x != '0) && (clo_x <= eff_cols);
    qry_ok   = upd_ok &&
               (rhi_x != '0) && (rhi_x <= eff_rows) &&
               (chi_x != '0) && (chi_x <= eff_cols) &&
               (rlo_x <= rhi_x) && (clo_x <= chi_x);
  end

  assign take = cmd_valid && cmd_ready;

  // index walk arithmetic
  always_comb begin
    lb_i     = wi & (~wi + IW'(1));
    lb_j     = wj & (~wj + IW'(1));
    i_up     = wi + lb_i;
    j_up     = wj + lb_j;
    i_dn     = wi - lb_i;
    j_dn     = wj - lb_j;
    i_up_end = VW'(i_up) > eff_rows;
    j_up_end = VW'(j_up) > eff_cols;
    i_dn_end = (i_dn == '0);
    j_dn_end = (j_dn == '0);
    q_empty  = (wi == '0) || (wj == '0);
    q_step   = q_empty || (i_dn_end && j_dn_end);
    q_last   = q_step && (pk == 2'd3);
    pk_n     = pk + 2'd1;
    rlo_m1   = lat_rlo - IW'(1);
    clo_m1   = lat_clo - IW'(1);
    nrow     = pk_n[1] ? rlo_m1 : lat_rhi;
    ncol     = pk_n[0] ? clo_m1 : lat_chi;
    wi_m1    = wi - IW'(1);
    wj_m1    = wj - IW'(1);
  end

  assign tree_raddr   = {wi_m1[CW-1:0], wj_m1[CW-1:0]};
  assign shadow_raddr = {rlo_m1[CW-1:0], clo_m1[CW-1:0]};
  assign tree_waddr   = clearing ? clr_addr : pipe_addr;
  assign shadow_waddr = clearing ? clr_addr : shadow_raddr;
  assign finish       = (state == fw2d_pkg::ST_FINISH) && (!res_valid || res_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fw2d_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = fw2d_pkg::ST_IDLE;
      end
      fw2d_pkg::ST_IDLE: begin
        if (take) begin
          unique case (mode) inside
            fw2d_pkg::MODE_SET, fw2d_pkg::MODE_ADD:
              state_next = upd_ok ? fw2d_pkg::ST_SHRD : fw2d_pkg::ST_FINISH;
            fw2d_pkg::MODE_QUERY:
              state_next = qry_ok ? fw2d_pkg::ST_QRY : fw2d_pkg::ST_FINISH;
            default:
              state_next = fw2d_pkg::ST_FINISH;
          endcase
        end
      end
      fw2d_pkg::ST_SHRD:  state_next = fw2d_pkg::ST_DELTA;
      fw2d_pkg::ST_DELTA: state_next = fw2d_pkg::ST_SHWR;
      fw2d_pkg::ST_SHWR:  state_next = fw2d_pkg::ST_UPD;
      fw2d_pkg::ST_UPD: begin
        if (i_up_end && j_up_end) state_next = fw2d_pkg::ST_DRAIN;
      end
      fw2d_pkg::ST_QRY: begin
        if (q_last) state_next = fw2d_pkg::ST_DRAIN;
      end
      fw2d_pkg::ST_DRAIN: state_next = fw2d_pkg::ST_FINISH;
      fw2d_pkg::ST_FINISH: begin
        if (finish) state_next = fw2d_pkg::ST_IDLE;
      end
      default: state_next = fw2d_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready = 1'b0;
    clearing  = 1'b0;
    issue     = 1'b0;
    shadow_we = 1'b0;
    tree_we   = 1'b0;
    alu_op    = fw2d_pkg::ALU_NOP;
    unique case (state)
      fw2d_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        tree_we   = 1'b1;
        shadow_we = 1'b1;
      end
      fw2d_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (take) begin
          alu_op = (mode == fw2d_pkg::MODE_QUERY) ? fw2d_pkg::ALU_CLR : fw2d_pkg::ALU_LOAD;
        end
      end
      fw2d_pkg::ST_DELTA: begin
        alu_op = lat_set ? fw2d_pkg::ALU_DSET : fw2d_pkg::ALU_NOP;
      end
      fw2d_pkg::ST_SHWR: begin
        alu_op    = fw2d_pkg::ALU_SHADOW;
        shadow_we = 1'b1;
      end
      fw2d_pkg::ST_UPD, fw2d_pkg::ST_QRY, fw2d_pkg::ST_DRAIN: begin
        issue = (state == fw2d_pkg::ST_UPD) || ((state == fw2d_pkg::ST_QRY) && !q_empty);
        if (pipe_v) begin
          if (lat_query) begin
            alu_op = pipe_neg ? fw2d_pkg::ALU_ACC_SUB : fw2d_pkg::ALU_ACC_ADD;
          end else begin
            alu_op  = fw2d_pkg::ALU_TREE;
            tree_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fw2d_pkg::ST_CLEAR;
      clr_addr  <= '0;
      pipe_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pipe_v <= issue;
      if (state == fw2d_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // item fields, walk indices, read pipe, result
  always_ff @(posedge clk) begin
    pipe_addr <= tree_raddr;
    pipe_neg  <= pk[0] ^ pk[1];
    if (take) begin
      lat_rlo   <= rlo_x[IW-1:0];
      lat_clo   <= clo_x[IW-1:0];
      lat_rhi   <= rhi_x[IW-1:0];
      lat_chi   <= chi_x[IW-1:0];
      lat_set   <= (mode == fw2d_pkg::MODE_SET);
      lat_query <= (mode == fw2d_pkg::MODE_QUERY);
      pk        <= 2'd0;
      if (mode == fw2d_pkg::MODE_QUERY) begin
        bad      <= !qry_ok;
        wi       <= rhi_x[IW-1:0];
        wj       <= chi_x[IW-1:0];
        col_base <= chi_x[IW-1:0];
      end else begin
        bad      <= !(upd_ok && (mode == fw2d_pkg::MODE_SET || mode == fw2d_pkg::MODE_ADD));
        wi       <= rlo_x[IW-1:0];
        wj       <= clo_x[IW-1:0];
        col_base <= clo_x[IW-1:0];
      end
    end else if (state == fw2d_pkg::ST_UPD) begin
      if (j_up_end) begin
        wi <= i_up;
        wj <= col_base;
      end else begin
        wj <= j_up;
      end
    end else if (state == fw2d_pkg::ST_QRY) begin
      if (q_step) begin
        pk       <= pk_n;
        wi       <= nrow;
        wj       <= ncol;
        col_base <= ncol;
      end else if (j_dn_end) begin
        wi <= i_dn;
        wj <= col_base;
      end else begin
        wj <= j_dn;
      end
    end
    if (finish) begin
      range_sum <= (lat_query && !bad) ? acc : '0;
      status    <= bad;
    end
  end

endmodule

>>> src/fenwick_2d_point_update_rect_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_point_update_rect_sum
// 2-D Fenwick tree with cell shadow: set, add and rectangle sum items.
// ----------------------------------------------------------------------------
// One item at a time. The index walks read tree entries on the single tree
// RAM read port; a read and the write-back or accumulate of the entry before
// it overlap. Set/add read the cell shadow, form the delta, write the shadow,
// then walk the tree upward in rows and columns (walk lengths at most 10 each
// at GRID_DIM 512), drain and finish. Query walks downward for each of the
// four prefix sums, with no read when a prefix is empty, then drains and
// finishes. Items with bad coordinates or mode 3 go straight to the result
// with status 1. The next item is taken while a result waits in the output
// register; an item that finishes while that result is still waiting holds in
// its last cycle until it is taken. After reset both stores are cleared, one
// entry a cycle, over all 4**clog2(GRID_DIM) entries (262144 at GRID_DIM 512);
// cmd_ready stays low until then, while register writes are accepted
// throughout. rows_used and cols_used above GRID_DIM act as GRID_DIM.
// ----------------------------------------------------------------------------
module fenwick_2d_point_update_rect_sum #(
  parameter int GRID_DIM = fw2d_pkg::GRID_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [fw2d_pkg::MODE_W-1:0]         mode,
  input  logic [fw2d_pkg::COORD_W-1:0]        row_lo,
  input  logic [fw2d_pkg::COORD_W-1:0]        col_lo,
  input  logic [fw2d_pkg::COORD_W-1:0]        row_hi,
  input  logic [fw2d_pkg::COORD_W-1:0]        col_hi,
  input  logic signed [fw2d_pkg::DATA_W-1:0]  value,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [fw2d_pkg::DATA_W-1:0]  range_sum,
  output logic                                status,
  input  logic                                cfg_we,
  input  logic [fw2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fw2d_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CW = $clog2(GRID_DIM);
  localparam int AW = 2 * CW;

  logic [fw2d_pkg::CFG_W-1:0]  rows_used;
  logic [fw2d_pkg::CFG_W-1:0]  cols_used;

  fw2d_pkg::alu_op_t           alu_op;
  logic                        clearing;
  logic [AW-1:0]               tree_raddr;
  logic                        tree_we;
  logic [AW-1:0]               tree_waddr;
  logic [fw2d_pkg::DATA_W-1:0] tree_wdata;
  logic [fw2d_pkg::DATA_W-1:0] tree_rd;
  logic [AW-1:0]               shadow_raddr;
  logic                        shadow_we;
  logic [AW-1:0]               shadow_waddr;
  logic [fw2d_pkg::DATA_W-1:0] shadow_wdata;
  logic [fw2d_pkg::DATA_W-1:0] shadow_rd;
  logic [fw2d_pkg::DATA_W-1:0] alu_sum;
  logic [fw2d_pkg::DATA_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= fw2d_pkg::USED_RESET;
      cols_used <= fw2d_pkg::USED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fw2d_pkg::REG_ROWS_USED: rows_used <= cfg_data;
        fw2d_pkg::REG_COLS_USED: cols_used <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign tree_wdata   = clearing ? '0 : alu_sum;
  assign shadow_wdata = clearing ? '0 : alu_sum;

  fw2d_ctrl #(
    .GRID_DIM (GRID_DIM),
    .CW       (CW),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .mode         (mode),
    .row_lo       (row_lo),
    .col_lo       (col_lo),
    .row_hi       (row_hi),
    .col_hi       (col_hi),
    .rows_used    (rows_used),
    .cols_used    (cols_used),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .range_sum    (range_sum),
    .status       (status),
    .acc          (acc),
    .alu_op       (alu_op),
    .clearing     (clearing),
    .tree_raddr   (tree_raddr),
    .tree_we      (tree_we),
    .tree_waddr   (tree_waddr),
    .shadow_raddr (shadow_raddr),
    .shadow_we    (shadow_we),
    .shadow_waddr (shadow_waddr)
  );

  fw2d_alu u_alu (
    .clk       (clk),
    .op        (alu_op),
    .value     (value),
    .tree_rd   (tree_rd),
    .shadow_rd (shadow_rd),
    .sum       (alu_sum),
    .acc       (acc)
  );

  fw2d_ram #(
    .AW (AW),
    .DW (fw2d_pkg::DATA_W)
  ) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rd)
  );

  fw2d_ram #(
    .AW (AW),
    .DW (fw2d_pkg::DATA_W)
  ) u_shadow (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (shadow_waddr),
    .wdata (shadow_wdata),
    .raddr (shadow_raddr),
    .rdata (shadow_rd)
  );

endmodule

>>> src/fw2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_checker
// Port-level checks for the 2-D Fenwick tree block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fenwick_2d_point_update_rect_sum_assert.svh"

module fw2d_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [fw2d_pkg::DATA_W-1:0] range_sum,
  input logic                               status
);

  `FW2D_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result item dropped while stalled")
  `FW2D_ASSERT_NXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(range_sum) && $stable(status), "stalled result changed")
  `FW2D_ASSERT_IMP(a_bad_zero, clk, rst, res_valid && status, range_sum == '0, "bad item with nonzero sum")
  `FW2D_ASSERT_NXT(a_one_item, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "second item taken while busy")
  `FW2D_ASSERT_NXT_ALL(a_rst_quiet, clk, rst, !cmd_ready && !res_valid, "not quiet after reset")

endmodule

bind fenwick_2d_point_update_rect_sum fw2d_checker u_fw2d_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .range_sum (range_sum),
  .status    (status)
);

>>> sim/fw2d_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw2d_sum_checker
// Watches the item, result and register ports of the 2-D Fenwick tree block.
// It keeps its own tree, cell shadow and grid size, works out the result of
// each accepted item, and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module fw2d_sum_checker
  import fw2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  logic                      cmd_ready,
  input  logic [MODE_W-1:0]         mode,
  input  logic [COORD_W-1:0]        row_lo,
  input  logic [COORD_W-1:0]        col_lo,
  input  logic [COORD_W-1:0]        row_hi,
  input  logic [COORD_W-1:0]        col_hi,
  input  logic signed [DATA_W-1:0]  value,
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  logic signed [DATA_W-1:0]  range_sum,
  input  logic                      status,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fails,
  output int                        pending
);

  localparam int GRID = GRID_DIM_DEF;

  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    logic                     st;
  } outcome_t;

  bit [DATA_W-1:0] bit_tree [GRID][GRID];
  bit [DATA_W-1:0] cell_val [GRID][GRID];
  int unsigned     rows_n = USED_RESET;
  int unsigned     cols_n = USED_RESET;
  bit              wiped = 1'b0;
  outcome_t        sums_q[$];
  int              fail_cnt = 0;

  function automatic int unsigned low_bit(int unsigned i);
    return i & (~i + 1);
  endfunction

  function automatic int unsigned clip(int unsigned v);
    return (v > GRID) ? GRID : v;
  endfunction

  function automatic bit fits(int unsigned v, int unsigned used);
    return (v >= 1) && (v <= clip(used));
  endfunction

  function automatic void spread(int unsigned r, int unsigned c, bit [DATA_W-1:0] d);
    int unsigned i;
    int unsigned j;
    int unsigned nr;
    int unsigned nc;
    nr = clip(rows_n);
    nc = clip(cols_n);
    for (i = r; i >= 1 && i <= nr; i += low_bit(i))
      for (j = c; j >= 1 && j <= nc; j += low_bit(j))
        bit_tree[i-1][j-1] += d;
  endfunction

  function automatic bit [DATA_W-1:0] corner_sum(int unsigned r, int unsigned c);
    bit [DATA_W-1:0] acc;
    int unsigned     i;
    int unsigned     j;
    acc = '0;
    for (i = r; i > 0; i -= low_bit(i))
      for (j = c; j > 0; j -= low_bit(j))
        acc += bit_tree[i-1][j-1];
    return acc;
  endfunction

  function automatic outcome_t predict(bit [MODE_W-1:0] m, int unsigned r1, int unsigned c1,
                                       int unsigned r2, int unsigned c2, bit [DATA_W-1:0] v);
    outcome_t        o;
    bit [DATA_W-1:0] d;
    o.sum = '0;
    o.st  = 1'b1;
    if (m == MODE_SET || m == MODE_ADD) begin
      if (fits(r1, rows_n) && fits(c1, cols_n)) begin
        d = (m == MODE_SET) ? v - cell_val[r1-1][c1-1] : v;
        spread(r1, c1, d);
        cell_val[r1-1][c1-1] += d;
        o.st = 1'b0;
      end
    end else if (m == MODE_QUERY) begin
      if (fits(r1, rows_n) && fits(r2, rows_n) && fits(c1, cols_n) && fits(c2, cols_n) &&
          r1 <= r2 && c1 <= c2) begin
        o.sum = corner_sum(r2, c2) - corner_sum(r2, c1 - 1)
              - corner_sum(r1 - 1, c2) + corner_sum(r1 - 1, c1 - 1);
        o.st  = 1'b0;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rows_n = USED_RESET;
      cols_n = USED_RESET;
      sums_q.delete();
      if (!wiped) begin
        for (int r = 0; r < GRID; r++)
          for (int c = 0; c < GRID; c++) begin
            bit_tree[r][c] = '0;
            cell_val[r][c] = '0;
          end
        wiped = 1'b1;
      end
    end else begin
      if (res_valid && res_ready) begin
        if (sums_q.size() == 0) begin
          $error("result with no item outstanding: range_sum %0d status %0d",
                 range_sum, status);
          fail_cnt++;
        end else begin
          want = sums_q.pop_front();
          if (range_sum !== want.sum) begin
            $error("range_sum: expected %0d, got %0d", want.sum, range_sum);
            fail_cnt++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_cnt++;
          end
        end
      end
      if (cmd_valid && cmd_ready)
        sums_q.push_back(predict(mode, row_lo, col_lo, row_hi, col_hi, value));
      if (cfg_we) begin
        if (cfg_index == REG_ROWS_USED) begin
          rows_n = cfg_data;
        end else if (cfg_index == REG_COLS_USED) begin
          cols_n = cfg_data;
        end
      end
    end
    pending <= sums_q.size();
    fails   <= fail_cnt;
  end

endmodule

>>> sim/fenwick_2d_point_update_rect_sum_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_point_update_rect_sum_test
// Drives set, add, rectangle query and unused-mode items into the 2-D Fenwick tree block
// over several grid sizes, with random gaps on both sides, and reports the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module fenwick_2d_point_update_rect_sum_test;
  import fw2d_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int N_PHASES = 8;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_ready;
  logic [MODE_W-1:0]         mode = MODE_SET;
  logic [COORD_W-1:0]        row_lo = '0;
  logic [COORD_W-1:0]        col_lo = '0;
  logic [COORD_W-1:0]        row_hi = '0;
  logic [COORD_W-1:0]        col_hi = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic signed [DATA_W-1:0]  range_sum;
  logic                      status;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_ROWS_USED;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        fails;
  int                        pending;

  int          tx_idle = 21;
  int          rx_idle = 61;
  int unsigned rows_cfg = USED_RESET;
  int unsigned cols_cfg = USED_RESET;

  int unsigned ph_rows [N_PHASES] = '{16, 1023, 0, 1, 37, 512, 3, 200};
  int unsigned ph_cols [N_PHASES] = '{16, 700, 300, 1, 5, 512, 1023, 9};
  int          ph_items[N_PHASES] = '{200, 200, 40, 60, 200, 400, 200, 200};

  always #1 clk = ~clk;

  fenwick_2d_point_update_rect_sum DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .mode      (mode),
    .row_lo    (row_lo),
    .col_lo    (col_lo),
    .row_hi    (row_hi),
    .col_hi    (col_hi),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .range_sum (range_sum),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fw2d_sum_checker u_sum_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .mode      (mode),
    .row_lo    (row_lo),
    .col_lo    (col_lo),
    .row_hi    (row_hi),
    .col_hi    (col_hi),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .range_sum (range_sum),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic issue(logic [MODE_W-1:0] m, int unsigned rl, int unsigned cl,
                       int unsigned rh, int unsigned ch, logic [DATA_W-1:0] v);
    while ($urandom_range(99) < tx_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    mode      <= m;
    row_lo    <= rl[COORD_W-1:0];
    col_lo    <= cl[COORD_W-1:0];
    row_hi    <= rh[COORD_W-1:0];
    col_hi    <= ch[COORD_W-1:0];
    value     <= v;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned r, int unsigned c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_USED;
    cfg_data  <= r[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_COLS_USED;
    cfg_data  <= c[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_cfg   = r;
    cols_cfg   = c;
  endtask

  function automatic int unsigned pick_coord(int unsigned used);
    int unsigned lim;
    int unsigned p;
    lim = (used > GRID_DIM_DEF) ? GRID_DIM_DEF : used;
    p   = $urandom_range(99);
    if (lim == 0 || p < 12)
      return $urandom_range(1023, 0);
    if (p < 27)
      return $urandom_range(1) ? 1 : lim;
    if (p < 62)
      return $urandom_range((lim < 6) ? lim : 6, 1);
    return $urandom_range(lim, 1);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25)
      return $urandom_range(16, 0) - 8;
    if (p < 40) begin
      case ($urandom_range(3))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'hffffffff;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_item();
    int unsigned p;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned d;
    int unsigned t;
    p = $urandom_range(99);
    if (p < 55) begin
      issue((p < 30) ? MODE_SET : MODE_ADD, pick_coord(rows_cfg), pick_coord(cols_cfg),
            $urandom_range(1023, 0), $urandom_range(1023, 0), pick_value());
    end else if (p < 95) begin
      a = pick_coord(rows_cfg);
      b = pick_coord(rows_cfg);
      c = pick_coord(cols_cfg);
      d = pick_coord(cols_cfg);
      if ($urandom_range(9) != 0 && a > b) begin
        t = a; a = b; b = t;
      end
      if ($urandom_range(9) != 0 && c > d) begin
        t = c; c = d; d = t;
      end
      issue(MODE_QUERY, a, c, b, d, $urandom);
    end else begin
      issue(MODE_UNUSED, $urandom_range(1023, 0), $urandom_range(1023, 0),
            $urandom_range(1023, 0), $urandom_range(1023, 0), $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items on the full grid
    issue(MODE_SET,   1,   1,   0,   0, 32'h7fffffff);
    issue(MODE_SET,   512, 512, 0,   0, 32'h80000000);
    issue(MODE_ADD,   1,   1,   0,   0, 32'd1);
    issue(MODE_ADD,   512, 1,   0,   0, 32'hffffffff);
    issue(MODE_SET,   1,   1,   0,   0, 32'd5);
    issue(MODE_SET,   1,   512, 0,   0, 32'h55555555);
    issue(MODE_ADD,   256, 300, 0,   0, 32'h12345678);
    issue(MODE_SET,   256, 300, 0,   0, 32'h12345678);
    issue(MODE_QUERY, 1,   1,   512, 512, 32'd0);
    issue(MODE_QUERY, 1,   1,   1,   1,   32'd0);
    issue(MODE_QUERY, 512, 512, 512, 512, 32'd0);
    issue(MODE_QUERY, 2,   2,   511, 511, 32'd0);
    issue(MODE_QUERY, 1,   1,   512, 1,   32'd0);
    issue(MODE_QUERY, 256, 300, 256, 300, 32'd0);
    issue(MODE_SET,   0,   5,   0,   0,   32'd7);
    issue(MODE_ADD,   5,   513, 0,   0,   32'd7);
    issue(MODE_ADD,   1023, 1023, 1023, 1023, 32'hffffffff);
    issue(MODE_QUERY, 10,  1,   9,   512, 32'd0);
    issue(MODE_QUERY, 1,   10,  512, 9,   32'd0);
    issue(MODE_QUERY, 1,   1,   1023, 512, 32'd0);
    issue(MODE_QUERY, 0,   1,   5,   5,   32'd0);
    issue(MODE_UNUSED, 1,  1,   1,   1,   32'd1);
    issue(MODE_QUERY, 1,   1,   512, 512, 32'd0);
    drain();

    // grid size changes keep the stored tree as it is
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 3) begin
        tx_idle = 21;
        rx_idle = 61;
      end else if (ph < 6) begin
        tx_idle = 61;
        rx_idle = 21;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      set_grid(ph_rows[ph], ph_cols[ph]);
      for (int n = 0; n < ph_items[ph]; n++)
        random_item();
      drain();
    end

    repeat (500) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
